>>> rtl/sss_pkg.sv
// Shared types and constants for the storage stack selector.
// Used by sss_select, sss_total and storage_stack_selector_top; no dependencies.

package sss_pkg;

   // Stack geometry
   localparam int NUM_STACKS = 12;
   localparam int STACK_W    = 4;
   localparam int COUNT_W    = 6;
   localparam int LIMIT_W    = 5;
   localparam int TOTAL_W    = 9;
   localparam int STATUS_W   = 2;
   localparam int REQ_W      = 3;

   localparam logic [STACK_W-1:0] NO_STACK = 4'd12;

   typedef logic signed [COUNT_W-1:0] count_type;
   typedef count_type [NUM_STACKS-1:0] count_array_type;

   localparam count_type COUNT_MAX = 6'sb011111;
   localparam count_type COUNT_MIN = 6'sb100000;

   // Request codes
   localparam logic [REQ_W-1:0] REQ_WRITE  = 3'd0;
   localparam logic [REQ_W-1:0] REQ_SLIDER = 3'd1;
   localparam logic [REQ_W-1:0] REQ_TAKE   = 3'd2;
   localparam logic [REQ_W-1:0] REQ_STORE  = 3'd3;
   localparam logic [REQ_W-1:0] REQ_INC    = 3'd4;
   localparam logic [REQ_W-1:0] REQ_DEC    = 3'd5;

   // Status codes
   localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] ST_SLIDER  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_BAY     = 2'd2;
   localparam logic [STATUS_W-1:0] ST_INVALID = 2'd3;

   // Register indexes
   localparam logic CSR_LOWER_LIMIT = 1'b0;
   localparam logic CSR_UPPER_LIMIT = 1'b1;

   // Outcome of a take or store selection
   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [STACK_W-1:0]  stack;
   } sel_result_type;

endpackage

>>> rtl/sss_select.sv
// Take and store selection over the twelve stack counts (combinational).
// Depends on sss_pkg.

module sss_select (
   input  sss_pkg::count_array_type      counts,
   input  logic                          slider_ext,
   input  logic [sss_pkg::LIMIT_W-1:0]   lower_limit,
   input  logic [sss_pkg::LIMIT_W-1:0]   upper_limit,
   input  logic                          is_store,
   output sss_pkg::sel_result_type       result
);

   // Count at or above an unsigned limit
   function automatic logic at_limit(sss_pkg::count_type c,
                                     logic [sss_pkg::LIMIT_W-1:0] lim);
      return $signed({c[sss_pkg::COUNT_W-1], c}) >= $signed({2'b00, lim});
   endfunction

   // Largest of three, lowest index wins a tie
   function automatic logic [sss_pkg::STACK_W-1:0] max3(sss_pkg::count_type a,
                                                       sss_pkg::count_type b,
                                                       sss_pkg::count_type c,
                                                       logic [sss_pkg::STACK_W-1:0] base);
      logic [sss_pkg::STACK_W-1:0] idx;
      sss_pkg::count_type          best;
      idx  = base;
      best = a;
      if (b > best) begin
         idx  = base + 4'd1;
         best = b;
      end
      if (c > best) begin
         idx = base + 4'd2;
      end
      return idx;
   endfunction

   // Smallest of three visited in order, first visited wins a tie
   function automatic logic [sss_pkg::STACK_W-1:0] min3(sss_pkg::count_type ca,
                                                       sss_pkg::count_type cb,
                                                       sss_pkg::count_type cc,
                                                       logic [sss_pkg::STACK_W-1:0] ia,
                                                       logic [sss_pkg::STACK_W-1:0] ib,
                                                       logic [sss_pkg::STACK_W-1:0] ic);
      logic [sss_pkg::STACK_W-1:0] idx;
      sss_pkg::count_type          best;
      idx  = ia;
      best = ca;
      if (cb < best) begin
         idx  = ib;
         best = cb;
      end
      if (cc < best) begin
         idx = ic;
      end
      return idx;
   endfunction

   logic                            neg_lo, neg_hi, zero_lo, zero_hi;
   logic                            full_lo, full_hi, full_c;
   logic [3:0]                      grp_pos, grp_nz;
   logic [sss_pkg::STACK_W-1:0]     min_a, min_b, min_c, min_d;
   sss_pkg::sel_result_type         take_res, store_res;

   // Per-half and per-group flags
   always_comb begin
      neg_lo  = 1'b0;
      neg_hi  = 1'b0;
      zero_lo = 1'b1;
      zero_hi = 1'b1;
      full_lo = 1'b1;
      full_hi = 1'b1;
      for (int i = 0; i < 6; i++) begin
         neg_lo  = neg_lo | counts[i][sss_pkg::COUNT_W-1];
         zero_lo = zero_lo & (counts[i] == '0);
         full_lo = full_lo & at_limit(counts[i], lower_limit);
         neg_hi  = neg_hi | counts[i+6][sss_pkg::COUNT_W-1];
         zero_hi = zero_hi & (counts[i+6] == '0);
         full_hi = full_hi & at_limit(counts[i+6], upper_limit);
      end
      full_c = at_limit(counts[6], upper_limit) & at_limit(counts[7], upper_limit) &
               at_limit(counts[8], upper_limit);
      for (int g = 0; g < 4; g++) begin
         grp_pos[g] = (counts[3*g] > 0) | (counts[3*g+1] > 0) | (counts[3*g+2] > 0);
         grp_nz[g]  = (counts[3*g] != '0) | (counts[3*g+1] != '0) | (counts[3*g+2] != '0);
      end
      min_a = min3(counts[2], counts[1], counts[0], 4'd2, 4'd1, 4'd0);
      min_b = min3(counts[5], counts[4], counts[3], 4'd5, 4'd4, 4'd3);
      min_c = min3(counts[8], counts[7], counts[6], 4'd8, 4'd7, 4'd6);
      min_d = min3(counts[9], counts[10], counts[11], 4'd9, 4'd10, 4'd11);
   end

   // Take: fullest stack in the first group holding items
   always_comb begin
      take_res.status = sss_pkg::ST_OK;
      take_res.stack  = sss_pkg::NO_STACK;
      if (slider_ext ? neg_hi : neg_lo) begin
         take_res.status = sss_pkg::ST_INVALID;
      end else if (!slider_ext && zero_lo) begin
         take_res.status = zero_hi ? sss_pkg::ST_BAY : sss_pkg::ST_SLIDER;
      end else if (slider_ext && zero_hi) begin
         take_res.status = sss_pkg::ST_BAY;
      end else begin
         for (int g = 3; g >= 0; g--) begin
            if (grp_pos[g]) begin
               take_res.stack = max3(counts[3*g], counts[3*g+1], counts[3*g+2],
                                     sss_pkg::STACK_W'(3*g));
            end
         end
      end
   end

   // Store: emptiest stack, with the group fallback rules
   always_comb begin
      store_res.status = sss_pkg::ST_OK;
      store_res.stack  = sss_pkg::NO_STACK;
      if (slider_ext ? neg_hi : neg_lo) begin
         store_res.status = sss_pkg::ST_INVALID;
      end else if (slider_ext && full_hi) begin
         store_res.status = sss_pkg::ST_SLIDER;
      end else if (!slider_ext && full_lo) begin
         store_res.status = sss_pkg::ST_BAY;
      end else if (grp_nz[0]) begin
         if (at_limit(counts[min_a], lower_limit)) begin
            store_res.status = sss_pkg::ST_BAY;
         end else begin
            store_res.stack = min_a;
         end
      end else if (grp_nz[1]) begin
         store_res.stack = at_limit(counts[min_b], lower_limit) ? 4'd2 : min_b;
      end else if (grp_nz[2]) begin
         if (at_limit(counts[min_c], upper_limit) != slider_ext) begin
            store_res.stack = slider_ext ? min_c : 4'd5;
         end else begin
            store_res.status = sss_pkg::ST_SLIDER;
         end
      end else if (grp_nz[3]) begin
         if (!slider_ext) begin
            store_res.status = sss_pkg::ST_SLIDER;
         end else begin
            store_res.stack = at_limit(counts[min_d], upper_limit) ? 4'd8 : min_d;
         end
      end else if (!slider_ext) begin
         if (!full_c) begin
            store_res.status = sss_pkg::ST_SLIDER;
         end else begin
            store_res.stack = 4'd5;
         end
      end else begin
         store_res.stack = 4'd11;
      end
   end

   assign result = is_store ? store_res : take_res;

endmodule

>>> rtl/sss_total.sv
// Sum of the positive stack counts (combinational).
// Depends on sss_pkg.

module sss_total (
   input  sss_pkg::count_array_type      counts,
   output logic [sss_pkg::TOTAL_W-1:0]   total
);

   logic [sss_pkg::TOTAL_W-1:0] half_lo, half_hi;

   // Two six-input sums, negative counts dropped
   always_comb begin
      half_lo = '0;
      half_hi = '0;
      for (int i = 0; i < 6; i++) begin
         if (!counts[i][sss_pkg::COUNT_W-1]) begin
            half_lo = half_lo + sss_pkg::TOTAL_W'(unsigned'(counts[i]));
         end
         if (!counts[i+6][sss_pkg::COUNT_W-1]) begin
            half_hi = half_hi + sss_pkg::TOTAL_W'(unsigned'(counts[i+6]));
         end
      end
      total = half_lo + half_hi;
   end

endmodule

>>> rtl/storage_stack_selector_top.sv
// Storage stack selector: top level with request register, stack state and result register.
// Depends on sss_pkg, sss_select and sss_total.
//
// Usage:
//   Requests enter on req_tvalid/req_tready; req_tuser carries the request code,
//   req_tdata the stack number, count value and slider position. Each request
//   gives exactly one result on rsp_tvalid/rsp_tready: status, current stack,
//   its count and the total of positive counts after the request.
//   The stack limits are written on the csr_ port (index 0 lower, 1 upper);
//   csr_ready is always high. Write them only while no request is in flight.
// Flow and throughput:
//   A request accepted into the request register is processed against the stack
//   state combinationally once the result register can advance, and its result
//   is then written into the result register and offered on rsp_tvalid. One
//   request per cycle is sustained while rsp_tready stays high; the work is one
//   pass of the selection compare logic and the twelve-input count adder.
// Reset:
//   All counts zero, slider retracted, no stack chosen, both limits 8,
//   both channels empty.
// Stall:
//   While rsp_tready is low the result holds; one more request can wait in the
//   request register, after which req_tready drops.

module storage_stack_selector_top (
   input  logic         clock,
   input  logic         reset,
   // request channel
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [15:0]  req_tdata,   // stack_sel[3:0], count_value[9:4], slider_value[10], zero
   input  logic [2:0]   req_tuser,   // req_type[2:0]
   // result channel
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [23:0]  rsp_tdata,   // status[1:0], chosen_stack[5:2], chosen_level[11:6],
                                     // total_items[20:12], zero
   // configuration channel
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic         csr_index,
   input  logic [4:0]   csr_data
);

   // Request register
   logic                              s1_vld_ff, s1_vld_in;
   logic [sss_pkg::REQ_W-1:0]         s1_type_ff;
   logic [sss_pkg::STACK_W-1:0]       s1_sel_ff;
   sss_pkg::count_type                s1_cnt_ff;
   logic                              s1_slider_ff;

   // Stack state
   sss_pkg::count_array_type          counts_ff, counts_in;
   logic                              slider_ff, slider_in;
   logic [sss_pkg::STACK_W-1:0]       cur_ff, cur_in;
   logic [sss_pkg::LIMIT_W-1:0]       llim_ff, llim_in, ulim_ff, ulim_in;

   // Result register
   logic                              rsp_vld_ff, rsp_vld_in;
   logic [sss_pkg::STATUS_W-1:0]      rsp_status_ff, rsp_status_in;
   logic [sss_pkg::STACK_W-1:0]       rsp_stack_ff;
   sss_pkg::count_type                rsp_level_ff, rsp_level_in;
   logic [sss_pkg::TOTAL_W-1:0]       rsp_total_ff, total_in;

   logic                              req_accept, out_adv, fire;
   sss_pkg::sel_result_type           sel_res;

   // Handshake
   assign out_adv    = !rsp_vld_ff || rsp_tready;
   assign fire       = s1_vld_ff && out_adv;
   assign req_tready = !s1_vld_ff || out_adv;
   assign req_accept = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   assign s1_vld_in  = req_accept ? 1'b1 : (fire ? 1'b0 : s1_vld_ff);
   assign rsp_vld_in = fire ? 1'b1 : (rsp_tready ? 1'b0 : rsp_vld_ff);

   // Selection and sum
   sss_select u_select (
      .counts      (counts_ff),
      .slider_ext  (slider_ff),
      .lower_limit (llim_ff),
      .upper_limit (ulim_ff),
      .is_store    (s1_type_ff == sss_pkg::REQ_STORE),
      .result      (sel_res)
   );

   sss_total u_total (
      .counts (counts_in),
      .total  (total_in)
   );

   // Limit register writes
   always_comb begin
      llim_in = llim_ff;
      ulim_in = ulim_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            sss_pkg::CSR_LOWER_LIMIT: llim_in = csr_data;
            sss_pkg::CSR_UPPER_LIMIT: ulim_in = csr_data;
            default:                  llim_in = llim_ff;
         endcase
      end
   end

   // State update for the request in the request register
   always_comb begin
      counts_in     = counts_ff;
      slider_in     = slider_ff;
      cur_in        = cur_ff;
      rsp_status_in = sss_pkg::ST_OK;
      if (fire) begin
         unique case (s1_type_ff)
            sss_pkg::REQ_WRITE: begin
               if (s1_sel_ff < sss_pkg::STACK_W'(sss_pkg::NUM_STACKS)) begin
                  counts_in[s1_sel_ff] = s1_cnt_ff;
               end
            end
            sss_pkg::REQ_SLIDER: begin
               slider_in = s1_slider_ff;
            end
            sss_pkg::REQ_TAKE, sss_pkg::REQ_STORE: begin
               cur_in        = sel_res.stack;
               rsp_status_in = sel_res.status;
            end
            sss_pkg::REQ_INC: begin
               if (cur_ff != sss_pkg::NO_STACK && counts_ff[cur_ff] != sss_pkg::COUNT_MAX) begin
                  counts_in[cur_ff] = counts_ff[cur_ff] + 6'sd1;
               end
            end
            sss_pkg::REQ_DEC: begin
               if (cur_ff != sss_pkg::NO_STACK && counts_ff[cur_ff] != sss_pkg::COUNT_MIN) begin
                  counts_in[cur_ff] = counts_ff[cur_ff] - 6'sd1;
               end
            end
            default: begin
               cur_in = cur_ff;
            end
         endcase
      end
      rsp_level_in = (cur_in != sss_pkg::NO_STACK) ? counts_in[cur_in] : '0;
   end

   // Control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
         counts_ff  <= '0;
         slider_ff  <= 1'b0;
         cur_ff     <= sss_pkg::NO_STACK;
         llim_ff    <= 5'd8;
         ulim_ff    <= 5'd8;
      end else begin
         s1_vld_ff  <= s1_vld_in;
         rsp_vld_ff <= rsp_vld_in;
         counts_ff  <= counts_in;
         slider_ff  <= slider_in;
         cur_ff     <= cur_in;
         llim_ff    <= llim_in;
         ulim_ff    <= ulim_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_type_ff   <= req_tuser;
         s1_sel_ff    <= req_tdata[3:0];
         s1_cnt_ff    <= req_tdata[9:4];
         s1_slider_ff <= req_tdata[10];
      end
      if (fire) begin
         rsp_status_ff <= rsp_status_in;
         rsp_stack_ff  <= cur_in;
         rsp_level_ff  <= rsp_level_in;
         rsp_total_ff  <= total_in;
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = {3'b000, rsp_total_ff, rsp_level_ff, rsp_stack_ff, rsp_status_ff};

   // Checks
   a_stack_range: assert property (@(posedge clock) disable iff (reset)
      cur_ff <= sss_pkg::NO_STACK)
      else $error("current stack out of range");

   a_fail_no_stack: assert property (@(posedge clock) disable iff (reset)
      rsp_vld_ff && rsp_status_ff != sss_pkg::ST_OK |-> rsp_stack_ff == sss_pkg::NO_STACK)
      else $error("failed selection left a stack chosen");

   a_none_level: assert property (@(posedge clock) disable iff (reset)
      rsp_vld_ff && rsp_stack_ff == sss_pkg::NO_STACK |-> rsp_level_ff == '0)
      else $error("level reported with no stack chosen");

   a_total_max: assert property (@(posedge clock) disable iff (reset)
      rsp_vld_ff |-> rsp_total_ff <= 9'd372)
      else $error("total above twelve full stacks");

   a_quiet_state: assert property (@(posedge clock) disable iff (reset)
      !fire |=> $stable(counts_ff) && $stable(cur_ff) && $stable(slider_ff))
      else $error("stack state changed without a request");

endmodule

>>> verif/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for storage_stack_selector_top: random and directed requests
// are checked against a behavioral predictor of the stack counts. Depends on sss_pkg.

module testbench;

   // Request codes the block treats as no-ops
   localparam logic [sss_pkg::REQ_W-1:0] REQ_SPARE_6 = 3'd6;
   localparam logic [sss_pkg::REQ_W-1:0] REQ_SPARE_7 = 3'd7;

   localparam int STALL_LIMIT    = 1000;
   localparam int PHASE_REQUESTS = 182;

   typedef struct {
      logic [sss_pkg::REQ_W-1:0]   kind;
      logic [sss_pkg::STACK_W-1:0] sel;
      sss_pkg::count_type          cnt;
      logic                        slider;
   } stack_req_type;

   typedef struct {
      logic [sss_pkg::STATUS_W-1:0] status;
      logic [sss_pkg::STACK_W-1:0]  stack;
      sss_pkg::count_type           level;
      logic [sss_pkg::TOTAL_W-1:0]  total;
   } stack_rsp_type;

   logic          clock      = 1'b0;
   logic          reset      = 1'b1;
   logic          req_tvalid = 1'b0;
   logic          req_tready;
   logic [15:0]   req_tdata  = '0;   // stack_sel[3:0], count_value[9:4], slider_value[10]
   logic [2:0]    req_tuser  = '0;   // req_type[2:0]
   logic          rsp_tvalid;
   logic          rsp_tready = 1'b0;
   logic [23:0]   rsp_tdata;         // status[1:0], chosen_stack[5:2], chosen_level[11:6],
                                     // total_items[20:12]
   logic          csr_valid  = 1'b0;
   logic          csr_ready;
   logic          csr_index  = 1'b0;
   logic [4:0]    csr_data   = '0;

   storage_stack_selector_top DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Predicted state of the stacks
   sss_pkg::count_type          level_of [sss_pkg::NUM_STACKS];
   logic                        extended;
   logic [sss_pkg::STACK_W-1:0] current;
   logic [sss_pkg::LIMIT_W-1:0] lower_limit;
   logic [sss_pkg::LIMIT_W-1:0] upper_limit;

   stack_req_type pending_requests[$];
   stack_rsp_type awaited_responses[$];
   stack_req_type driven_request;
   int            send_idle_pct  = 30;
   int            recv_idle_pct  = 61;
   int            error_count    = 0;
   int            idle_cycles    = 0;
   int            scenario_items = 0;

   function automatic bit group_zero(int first, int n);
      for (int i = first; i < first + n; i++)
         if (level_of[i] != 0) return 1'b0;
      return 1'b1;
   endfunction

   function automatic bit group_at_least(int first, int n, int lim);
      for (int i = first; i < first + n; i++)
         if (level_of[i] < lim) return 1'b0;
      return 1'b1;
   endfunction

   function automatic bit any_negative(int first);
      for (int i = first; i < first + 6; i++)
         if (level_of[i] < 0) return 1'b1;
      return 1'b0;
   endfunction

   // Smallest of three stacks; the first one named wins ties
   function automatic int min3(int a, int b, int c);
      int best;
      best = a;
      if (level_of[b] < level_of[best]) best = b;
      if (level_of[c] < level_of[best]) best = c;
      return best;
   endfunction

   // Fullest stack of the first group holding items
   function automatic logic [sss_pkg::STATUS_W-1:0] select_for_take();
      int best;
      bit found;
      found   = 1'b0;
      current = sss_pkg::NO_STACK;
      if (any_negative(extended ? 6 : 0)) return sss_pkg::ST_INVALID;
      if (!extended && group_zero(0, 6))
         return group_zero(6, 6) ? sss_pkg::ST_BAY : sss_pkg::ST_SLIDER;
      if (extended && group_zero(6, 6)) return sss_pkg::ST_BAY;
      for (int g = 0; g < sss_pkg::NUM_STACKS; g += 3) begin
         if (!found && (level_of[g] > 0 || level_of[g+1] > 0 || level_of[g+2] > 0)) begin
            best = g;
            if (level_of[g+1] > level_of[best]) best = g + 1;
            if (level_of[g+2] > level_of[best]) best = g + 2;
            current = sss_pkg::STACK_W'(best);
            found   = 1'b1;
         end
      end
      return sss_pkg::ST_OK;
   endfunction

   // Emptiest stack, with the group fallback rules
   function automatic logic [sss_pkg::STATUS_W-1:0] select_for_store();
      int m;
      int lo;
      int up;
      lo      = int'(lower_limit);
      up      = int'(upper_limit);
      current = sss_pkg::NO_STACK;
      if (any_negative(extended ? 6 : 0)) return sss_pkg::ST_INVALID;
      if (extended && group_at_least(6, 6, up)) return sss_pkg::ST_SLIDER;
      if (!extended && group_at_least(0, 6, lo)) return sss_pkg::ST_BAY;
      if (!group_zero(0, 3)) begin
         m = min3(2, 1, 0);
         if (level_of[m] >= lo) return sss_pkg::ST_BAY;
         current = sss_pkg::STACK_W'(m);
         return sss_pkg::ST_OK;
      end
      if (!group_zero(3, 3)) begin
         m = min3(5, 4, 3);
         current = (level_of[m] >= lo) ? sss_pkg::STACK_W'(2) : sss_pkg::STACK_W'(m);
         return sss_pkg::ST_OK;
      end
      if (!group_zero(6, 3)) begin
         m = min3(8, 7, 6);
         if (level_of[m] >= up) begin
            if (extended) return sss_pkg::ST_SLIDER;
            current = sss_pkg::STACK_W'(5);
            return sss_pkg::ST_OK;
         end
         if (!extended) return sss_pkg::ST_SLIDER;
         current = sss_pkg::STACK_W'(m);
         return sss_pkg::ST_OK;
      end
      if (!group_zero(9, 3)) begin
         if (!extended) return sss_pkg::ST_SLIDER;
         m = min3(9, 10, 11);
         current = (level_of[m] >= up) ? sss_pkg::STACK_W'(8) : sss_pkg::STACK_W'(m);
         return sss_pkg::ST_OK;
      end
      if (!extended) begin
         if (!group_at_least(6, 3, up)) return sss_pkg::ST_SLIDER;
         current = sss_pkg::STACK_W'(5);
         return sss_pkg::ST_OK;
      end
      current = sss_pkg::STACK_W'(11);
      return sss_pkg::ST_OK;
   endfunction

   // Apply one request to the predicted state and return the expected response
   function automatic stack_rsp_type stack_outcome(stack_req_type r);
      stack_rsp_type o;
      int sum;
      o.status = sss_pkg::ST_OK;
      case (r.kind)
         sss_pkg::REQ_WRITE:
            if (r.sel < sss_pkg::NUM_STACKS) level_of[r.sel] = r.cnt;
         sss_pkg::REQ_SLIDER: extended = r.slider;
         sss_pkg::REQ_TAKE:   o.status = select_for_take();
         sss_pkg::REQ_STORE:  o.status = select_for_store();
         sss_pkg::REQ_INC:
            if (current < sss_pkg::NUM_STACKS && level_of[current] < sss_pkg::COUNT_MAX)
               level_of[current] = sss_pkg::count_type'(level_of[current] + 1);
         sss_pkg::REQ_DEC:
            if (current < sss_pkg::NUM_STACKS && level_of[current] > sss_pkg::COUNT_MIN)
               level_of[current] = sss_pkg::count_type'(level_of[current] - 1);
         default: ;
      endcase
      sum = 0;
      for (int i = 0; i < sss_pkg::NUM_STACKS; i++)
         if (level_of[i] > 0) sum += int'(level_of[i]);
      o.total = sss_pkg::TOTAL_W'(sum);
      o.stack = current;
      o.level = (current < sss_pkg::NUM_STACKS) ? level_of[current] : sss_pkg::count_type'(0);
      return o;
   endfunction

   task automatic queue_request(logic [sss_pkg::REQ_W-1:0] kind, int sel, int cnt,
                                logic slider);
      stack_req_type r;
      r.kind   = kind;
      r.sel    = sss_pkg::STACK_W'(sel);
      r.cnt    = sss_pkg::count_type'(cnt);
      r.slider = slider;
      pending_requests.push_back(r);
      scenario_items++;
   endtask

   // Count biased toward the limit of the stack's half
   function automatic int rand_count(int lim);
      int r;
      r = $urandom_range(99);
      if (r < 20) return lim;
      if (r < 35) return 0;
      if (r < 70) return $urandom_range(lim, 0);
      if (r < 90) return $urandom_range(31, lim);
      return -int'($urandom_range(32, 1));
   endfunction

   // Refill or clear some groups, maybe move the slider, then select and adjust
   task automatic random_scenario();
      int r;
      int s;
      int n;
      stack_req_type noise;
      for (int g = 0; g < 4; g++) begin
         r = $urandom_range(99);
         if (r < 35) begin
            for (int k = 0; k < 3; k++)
               queue_request(sss_pkg::REQ_WRITE, g * 3 + k, 0, 1'($urandom));
         end else if (r < 65) begin
            s = g * 3 + $urandom_range(2);
            queue_request(sss_pkg::REQ_WRITE, s,
                          rand_count(s < 6 ? int'(lower_limit) : int'(upper_limit)),
                          1'($urandom));
         end
      end
      if ($urandom_range(3) == 0)
         queue_request(sss_pkg::REQ_SLIDER, $urandom_range(15), $urandom, 1'($urandom));
      n = $urandom_range(6, 1);
      for (int k = 0; k < n; k++) begin
         r = $urandom_range(99);
         queue_request(r < 30 ? sss_pkg::REQ_TAKE : r < 60 ? sss_pkg::REQ_STORE :
                       r < 80 ? sss_pkg::REQ_INC : sss_pkg::REQ_DEC,
                       $urandom_range(15), $urandom, 1'($urandom));
      end
      // Occasional fully random request, including spare codes and out-of-range stacks
      if ($urandom_range(9) == 0) begin
         noise.kind   = sss_pkg::REQ_W'($urandom);
         noise.sel    = sss_pkg::STACK_W'($urandom);
         noise.cnt    = sss_pkg::count_type'($urandom);
         noise.slider = 1'($urandom);
         pending_requests.push_back(noise);
      end
   endtask

   task automatic write_limit(logic idx, logic [sss_pkg::LIMIT_W-1:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      if (idx == sss_pkg::CSR_LOWER_LIMIT) lower_limit = val;
      else upper_limit = val;
      csr_valid <= 1'b0;
   endtask

   task automatic wait_drained();
      while (pending_requests.size() != 0 || req_tvalid || awaited_responses.size() != 0)
         @(posedge clock);
   endtask

   task automatic check_field(string name, int want, int got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         error_count++;
      end
   endtask

   // Request driver
   always @(posedge clock) begin : driver
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready)
            awaited_responses.push_back(stack_outcome(driven_request));
         if (!req_tvalid || req_tready) begin
            if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               driven_request = pending_requests.pop_front();
               req_tuser  <= driven_request.kind;
               req_tdata  <= {5'b0, driven_request.slider, driven_request.cnt,
                              driven_request.sel};
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Response monitor and checker
   always @(posedge clock) begin : monitor
      stack_rsp_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (awaited_responses.size() == 0) begin
               $error("response with no request outstanding");
               error_count++;
            end else begin
               want = awaited_responses.pop_front();
               check_field("status", int'(want.status), int'(rsp_tdata[1:0]));
               check_field("chosen_stack", int'(want.stack), int'(rsp_tdata[5:2]));
               check_field("chosen_level", int'(want.level), int'($signed(rsp_tdata[11:6])));
               check_field("total_items", int'(want.total), int'(rsp_tdata[20:12]));
            end
         end
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Watchdog: too long without any handshake
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_valid && csr_ready))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("testbench failed");
            $finish;
         end
      end
   end

   initial begin
      int start;
      int lo;
      int up;
      for (int i = 0; i < sss_pkg::NUM_STACKS; i++) level_of[i] = '0;
      extended    = 1'b0;
      current     = sss_pkg::NO_STACK;
      lower_limit = 5'd8;
      upper_limit = 5'd8;

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed part at the reset limits
      queue_request(sss_pkg::REQ_TAKE, 0, 0, 1'b0);        // empty bay
      queue_request(sss_pkg::REQ_STORE, 0, 0, 1'b0);       // all zero, retracted
      queue_request(sss_pkg::REQ_INC, 15, -1, 1'b1);       // nothing chosen
      queue_request(sss_pkg::REQ_DEC, 0, 0, 1'b0);
      queue_request(sss_pkg::REQ_SLIDER, 0, 0, 1'b1);
      queue_request(sss_pkg::REQ_STORE, 0, 0, 1'b0);       // all zero, extended
      queue_request(sss_pkg::REQ_WRITE, 11, 30, 1'b0);     // write keeps the chosen stack
      queue_request(sss_pkg::REQ_INC, 0, 0, 1'b0);
      queue_request(sss_pkg::REQ_INC, 0, 0, 1'b0);         // saturates high
      queue_request(sss_pkg::REQ_WRITE, 11, -31, 1'b0);
      queue_request(sss_pkg::REQ_DEC, 0, 0, 1'b0);
      queue_request(sss_pkg::REQ_DEC, 0, 0, 1'b0);         // saturates low
      queue_request(sss_pkg::REQ_TAKE, 0, 0, 1'b0);        // negative count in use
      queue_request(sss_pkg::REQ_STORE, 0, 0, 1'b0);
      queue_request(sss_pkg::REQ_WRITE, 12, 5, 1'b1);      // stack out of range
      queue_request(sss_pkg::REQ_WRITE, 15, 31, 1'b0);
      queue_request(sss_pkg::REQ_WRITE, 11, 0, 1'b0);
      queue_request(sss_pkg::REQ_WRITE, 4, 3, 1'b0);
      queue_request(sss_pkg::REQ_SLIDER, 15, -32, 1'b0);
      queue_request(sss_pkg::REQ_TAKE, 0, 0, 1'b0);
      queue_request(sss_pkg::REQ_WRITE, 1, 8, 1'b0);
      queue_request(sss_pkg::REQ_STORE, 0, 0, 1'b0);
      queue_request(REQ_SPARE_6, 7, 31, 1'b1);
      queue_request(REQ_SPARE_7, 8, -32, 1'b0);
      queue_request(sss_pkg::REQ_STORE, 0, 0, 1'b0);
      wait_drained();

      // Random phases over a range of limit settings
      for (int p = 0; p < 6; p++) begin
         send_idle_pct = (p < 2) ? 30 : (p < 4) ? 61 : 0;
         recv_idle_pct = (p < 2) ? 61 : (p < 4) ? 30 : 0;
         case (p)
            0:       begin lo = 3;  up = 5;  end
            1:       begin lo = 0;  up = 31; end
            2:       begin lo = 31; up = 0;  end
            3:       begin lo = $urandom_range(31); up = $urandom_range(31); end
            4:       begin lo = 31; up = 31; end
            default: begin lo = $urandom_range(12, 1); up = $urandom_range(12, 1); end
         endcase
         write_limit(sss_pkg::CSR_LOWER_LIMIT, sss_pkg::LIMIT_W'(lo));
         write_limit(sss_pkg::CSR_UPPER_LIMIT, sss_pkg::LIMIT_W'(up));
         start = scenario_items;
         while (scenario_items - start < PHASE_REQUESTS) random_scenario();
         wait_drained();
      end

      repeat (8) @(posedge clock);
      if (awaited_responses.size() != 0) begin
         $error("%0d responses never arrived", awaited_responses.size());
         error_count++;
      end
      if (error_count == 0)
         $display("testbench passed");
      else
         $display("testbench failed");
      $finish;
   end

endmodule

>>> filelist.f
rtl/sss_pkg.sv
rtl/sss_select.sv
rtl/sss_total.sv
rtl/storage_stack_selector_top.sv
verif/testbench.sv
